>>> design/i2cbm_pkg.sv
package i2cbm_pkg;

  localparam int HOLD_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_COUNT_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT_TICKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] UNIT_TICKS_RESET = 16'd50;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // sequencer phases
  localparam logic [3:0] PH_STEP0 = 4'd0;
  localparam logic [3:0] PH_STEP1 = 4'd1;
  localparam logic [3:0] PH_STEP2 = 4'd2;
  localparam logic [3:0] PH_STEP3 = 4'd3;
  localparam logic [3:0] PH_STEP4 = 4'd4;
  localparam logic [3:0] PH_END = 4'd15;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WAIT  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
  } res_t;

  // classified tick, as it waits in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] shift_init;
    logic       ack;
    logic       sda;
  } ticket_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

>>> design/i2c_bit_level_master.sv
// I2C master line sequencer, one input item per clock tick of the bus timing.
// in_item carries a command (start, stop, write byte, read byte, wait for ack)
// and the sampled SDA level; a command is taken only while the sequencer is
// idle, otherwise it is ignored. Every input item yields exactly one result
// item on out_item: SCL/SDA levels, SDA drive enable, busy, done pulse, the
// last read byte and the ack timeout flag, all showing the state after the tick.
// Holds last 1, 2 or 4 units of unit_ticks ticks each (config index 0);
// ack_timeout (config index 1) bounds the SDA-high polls of an ack wait.
// The cfg channel is always ready; write it only while the block is idle.
// An item passes through the queue and then the output register before
// out_valid rises. Throughput is one item per cycle while out_stall is low,
// as the sequencer steps once for each item popped in the back end.
// A 2-entry queue sits between input decode and the sequencer; in_stall rises
// once both entries are held behind a stalled output register.
// Reset: SCL and SDA high and driven, idle, unit_ticks 50, ack_timeout 250,
// queue and output register empty.
module i2c_bit_level_master #(
  parameter int HOLD_COUNTER_BITS = i2cbm_pkg::HOLD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  i2cbm_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output i2cbm_pkg::res_t                      out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [i2cbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import i2cbm_pkg::*;

  queue_status_t q_status;
  ticket_t       push_ticket;
  ticket_t       head;
  logic          push;
  logic          pop;

  assign cfg_ready = 1'b1;

  i2cbm_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .q_status    (q_status),
    .push        (push),
    .push_ticket (push_ticket)
  );

  i2cbm_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_ticket (push_ticket),
    .pop         (pop),
    .head        (head),
    .status      (q_status)
  );

  i2cbm_back #(
    .HOLD_COUNTER_BITS (HOLD_COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> design/i2cbm_front.sv
module i2cbm_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  i2cbm_pkg::in_item_t    in_item,
  input  i2cbm_pkg::queue_status_t q_status,
  output logic                   push,
  output i2cbm_pkg::ticket_t     push_ticket
);
  import i2cbm_pkg::*;

  op_t op;

  // commands outside the known set count as none
  always_comb begin
    case (in_item.command)
      OP_START: op = OP_START;
      OP_STOP:  op = OP_STOP;
      OP_WRITE: op = OP_WRITE;
      OP_READ:  op = OP_READ;
      OP_WAIT:  op = OP_WAIT;
      default: op = OP_IDLE;
    endcase
  end

  assign in_stall = q_status.full;
  assign push = in_valid && !q_status.full;

  always_comb begin
    push_ticket.op = op;
    push_ticket.shift_init = (op == OP_WRITE) ? in_item.write_data : 8'd0;
    push_ticket.ack = in_item.send_ack;
    push_ticket.sda = in_item.sda_in;
  end

endmodule

>>> design/i2cbm_queue.sv
module i2cbm_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  i2cbm_pkg::ticket_t       push_ticket,
  input  logic                     pop,
  output i2cbm_pkg::ticket_t       head,
  output i2cbm_pkg::queue_status_t status
);
  import i2cbm_pkg::*;

  ticket_t                     entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [QUEUE_COUNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_ticket;
  end

  assign head = entries[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full = (count == QUEUE_COUNT_BITS'(QUEUE_DEPTH));

endmodule

>>> design/i2cbm_back.sv
module i2cbm_back #(
  parameter int HOLD_COUNTER_BITS = i2cbm_pkg::HOLD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  i2cbm_pkg::queue_status_t               q_status,
  input  i2cbm_pkg::ticket_t                     head,
  output logic                                   pop,
  input  logic                                   cfg_write,
  input  logic [i2cbm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [i2cbm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output i2cbm_pkg::res_t                        out_item
);
  import i2cbm_pkg::*;

  localparam int HB = HOLD_COUNTER_BITS;
  localparam int PW = (HB > 18) ? HB : 18;
  localparam logic [PW-1:0] HOLD_CAP = PW'((64'd1 << HB) - 64'd1);

  function automatic logic [HB-1:0] sat(input logic [PW-1:0] v);
    sat = (v > HOLD_CAP) ? HOLD_CAP[HB-1:0] : v[HB-1:0];
  endfunction

  logic [15:0] unit_ticks;
  logic [7:0]  ack_timeout;

  op_t         cur_op, cur_op_next;
  logic [3:0]  phase, phase_next;
  logic [HB-1:0] hold_count, hold_count_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  wait_count, wait_count_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        drv, drv_next;
  logic        error_flag, error_flag_next;
  logic        ack_choice, ack_choice_next;
  logic [7:0]  last_read, last_read_next;
  logic        done;

  logic          started;
  logic          run;
  op_t           e_op;
  logic [3:0]    e_phase;
  logic [PW-1:0] ut_w;
  logic [HB-1:0] hold1, hold2, hold4;

  assign pop = q_status.valid && (!out_valid || !out_stall);

  assign ut_w = PW'(unit_ticks);
  assign hold1 = sat(ut_w);
  assign hold2 = sat(ut_w << 1);
  assign hold4 = sat(ut_w << 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_UNIT_TICKS) unit_ticks <= cfg_data;
      else if (cfg_index == CFG_ACK_TIMEOUT) ack_timeout <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op <= OP_IDLE;
      phase <= PH_STEP0;
      hold_count <= '0;
      bit_index <= '0;
      shift_byte <= '0;
      wait_count <= '0;
      scl <= 1'b1;
      sda <= 1'b1;
      drv <= 1'b1;
      error_flag <= 1'b0;
      ack_choice <= 1'b0;
      last_read <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_op <= cur_op_next;
        phase <= phase_next;
        hold_count <= hold_count_next;
        bit_index <= bit_index_next;
        shift_byte <= shift_byte_next;
        wait_count <= wait_count_next;
        scl <= scl_next;
        sda <= sda_next;
        drv <= drv_next;
        error_flag <= error_flag_next;
        ack_choice <= ack_choice_next;
        last_read <= last_read_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.scl_level <= scl_next;
      out_item.sda_level <= sda_next;
      out_item.sda_drive <= drv_next;
      out_item.busy_res <= (cur_op_next != OP_IDLE);
      out_item.done_res <= done;
      out_item.read_byte <= last_read_next;
      out_item.ack_error <= error_flag_next;
    end
  end

  always_comb begin
    started = (cur_op == OP_IDLE) && (head.op != OP_IDLE);
    run = started || ((cur_op != OP_IDLE) && (hold_count == '0));
    e_op = started ? head.op : cur_op;
    e_phase = started ? PH_STEP0 : phase;

    cur_op_next = e_op;
    phase_next = e_phase;
    bit_index_next = started ? 4'd0 : bit_index;
    wait_count_next = started ? 8'd0 : wait_count;
    shift_byte_next = started ? head.shift_init : shift_byte;
    ack_choice_next = started ? head.ack : ack_choice;
    if (started) hold_count_next = '0;
    else if (hold_count != '0) hold_count_next = hold_count - 1'b1;
    else hold_count_next = hold_count;
    scl_next = scl;
    sda_next = sda;
    drv_next = drv;
    error_flag_next = error_flag;
    last_read_next = last_read;
    done = 1'b0;

    if (run) begin
      case (e_op)
        OP_START: begin
          case (e_phase)
            PH_STEP0: begin
              drv_next = 1'b1; sda_next = 1'b1; phase_next = PH_STEP1;
            end
            PH_STEP1: begin
              scl_next = 1'b1; phase_next = PH_STEP2;
            end
            PH_STEP2: begin
              sda_next = 1'b0; hold_count_next = hold4; phase_next = PH_STEP3;
            end
            PH_STEP3: begin
              scl_next = 1'b0; phase_next = PH_END;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_STOP: begin
          case (e_phase)
            PH_STEP0: begin
              drv_next = 1'b1; scl_next = 1'b0; phase_next = PH_STEP1;
            end
            PH_STEP1: begin
              sda_next = 1'b0; hold_count_next = hold4; phase_next = PH_STEP2;
            end
            PH_STEP2: begin
              scl_next = 1'b1; phase_next = PH_STEP3;
            end
            PH_STEP3: begin
              sda_next = 1'b1; hold_count_next = hold4; phase_next = PH_END;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_WRITE: begin
          case (e_phase)
            PH_STEP0: begin
              drv_next = 1'b1;
              sda_next = shift_byte_next[7];
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              hold_count_next = hold2;
              phase_next = PH_STEP1;
            end
            PH_STEP1: begin
              scl_next = 1'b1; hold_count_next = hold2; phase_next = PH_STEP2;
            end
            PH_STEP2: begin
              scl_next = 1'b0;
              hold_count_next = hold2;
              bit_index_next = bit_index_next + 4'd1;
              phase_next = (bit_index_next >= BITS_PER_BYTE) ? PH_END : PH_STEP0;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_READ: begin
          case (e_phase)
            PH_STEP0: begin
              drv_next = 1'b0; scl_next = 1'b0;
              hold_count_next = hold2; phase_next = PH_STEP1;
            end
            PH_STEP1: begin
              scl_next = 1'b1;
              shift_byte_next = {shift_byte_next[6:0], head.sda};
              hold_count_next = hold1;
              bit_index_next = bit_index_next + 4'd1;
              phase_next = (bit_index_next >= BITS_PER_BYTE) ? PH_STEP2 : PH_STEP0;
            end
            PH_STEP2: begin
              scl_next = 1'b0;
              last_read_next = shift_byte_next;
              drv_next = 1'b1;
              sda_next = !ack_choice_next;
              hold_count_next = hold2;
              phase_next = PH_STEP3;
            end
            PH_STEP3: begin
              scl_next = 1'b1; hold_count_next = hold2; phase_next = PH_STEP4;
            end
            PH_STEP4: begin
              scl_next = 1'b0; phase_next = PH_END;
            end
            default: phase_next = PH_END;
          endcase
        end
        OP_WAIT: begin
          case (e_phase)
            PH_STEP0: begin
              drv_next = 1'b0; sda_next = 1'b1;
              hold_count_next = hold1; phase_next = PH_STEP1;
            end
            PH_STEP1: begin
              scl_next = 1'b1; hold_count_next = hold1; phase_next = PH_STEP2;
            end
            PH_STEP2: begin
              if (!head.sda) begin
                scl_next = 1'b0;
                error_flag_next = 1'b0;
                phase_next = PH_END;
              end else if (wait_count_next < ack_timeout) begin
                wait_count_next = wait_count_next + 8'd1;
              end else begin
                // timeout: first step of a stop sequence on this tick
                error_flag_next = 1'b1;
                cur_op_next = OP_STOP;
                drv_next = 1'b1;
                scl_next = 1'b0;
                phase_next = PH_STEP1;
              end
            end
            default: phase_next = PH_END;
          endcase
        end
        default: phase_next = PH_END;
      endcase
    end

    if ((cur_op_next != OP_IDLE) && (phase_next == PH_END) && (hold_count_next == '0)) begin
      cur_op_next = OP_IDLE;
      phase_next = PH_STEP0;
      done = 1'b1;
    end
  end

endmodule
